@@ hw/rtl/fifo_with_search_and_remove_macros.svh @@
// Assertion macros for the search-and-remove FIFO checker.
`ifndef FIFO_WITH_SEARCH_AND_REMOVE_MACROS_SVH
`define FIFO_WITH_SEARCH_AND_REMOVE_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define FWSR_ASSERT_IMM(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fwsr check failed");

// next-cycle implication, clocked on aclk, off during reset
`define FWSR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fwsr check failed");

`endif

@@ hw/rtl/fwsr_pkg.sv @@
// Shared types, codes and constants of the search-and-remove FIFO.
package fwsr_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int CODE_WIDTH_DEF = 32;

    localparam int ITEM_W    = 32;
    localparam int POS_W     = 5;
    localparam int OCC_W     = 5;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    typedef enum logic [1:0] {
        REQ_ENQ    = 2'd0,
        REQ_DEQ    = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_REMOVE = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_NOPOS = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic dispatch;
        logic deq_pop;
        logic scan_step;
        logic shift_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic go_deq;
        logic go_scan;
        logic go_shift;
        logic more;
    } stat_t;

endpackage

@@ hw/rtl/fwsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fwsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/fwsr_datapath.sv @@
// Datapath: request capture, head and count, entry walk pointers and result register.
module fwsr_datapath #(
    parameter int DEPTH      = fwsr_pkg::DEPTH_DEF,
    parameter int CODE_WIDTH = fwsr_pkg::CODE_WIDTH_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  fwsr_pkg::cmd_t                                    cmd,
    output fwsr_pkg::stat_t                                   stat,
    input  logic [fwsr_pkg::S_TDATA_W-1:0]                    s_tdata,
    input  logic [fwsr_pkg::S_TUSER_W-1:0]                    s_tuser,
    output logic [fwsr_pkg::M_TDATA_W-1:0]                    m_tdata,
    output logic [fwsr_pkg::M_TUSER_W-1:0]                    m_tuser,
    output logic                                              ram_we,
    output logic [$clog2(DEPTH)-1:0]                          ram_waddr,
    output logic [((CODE_WIDTH < fwsr_pkg::ITEM_W) ? CODE_WIDTH : fwsr_pkg::ITEM_W)-1:0]
                                                              ram_wdata,
    output logic                                              ram_re,
    output logic [$clog2(DEPTH)-1:0]                          ram_raddr,
    input  logic [((CODE_WIDTH < fwsr_pkg::ITEM_W) ? CODE_WIDTH : fwsr_pkg::ITEM_W)-1:0]
                                                              ram_rdata
);

    import fwsr_pkg::*;

    localparam int SW    = (CODE_WIDTH < ITEM_W) ? CODE_WIDTH : ITEM_W;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SUM_W = CMP_W + 1;

    // slot of (base + off), off below DEPTH: one compare and subtract
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CMP_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    req_type_t            req_reg, req_next;
    logic [SW-1:0]        code_reg, code_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     rslot_reg, rslot_next;
    logic [IDX_W-1:0]     wslot_reg, wslot_next;
    status_t              status_reg, status_next;
    logic                 found_reg, found_next;
    logic [SW-1:0]        code_out_reg, code_out_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic [CMP_W-1:0]     count_x;
    logic [CMP_W-1:0]     pos_x;
    logic [CNT_W:0]       idx_p1;
    logic                 full;
    logic                 empty;
    logic                 pos_bad;
    logic                 pos_zero;
    logic [ITEM_W-1:0]    code_ext;

    assign count_x  = CMP_W'(count_reg);
    assign pos_x    = CMP_W'(pos_reg);
    assign idx_p1   = {1'b0, idx_reg} + (CNT_W + 1)'(1);
    assign full     = count_reg >= CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pos_bad  = pos_x > count_x;
    assign pos_zero = pos_reg == '0;

    always_comb begin
        stat.go_deq   = (req_reg == REQ_DEQ) && !empty;
        stat.go_scan  = (req_reg == REQ_SEARCH) && !empty;
        stat.go_shift = (req_reg == REQ_REMOVE) && !pos_bad && !pos_zero && (pos_x != count_x);
        // search: reads left; remove: shifts left
        if (req_reg == REQ_REMOVE) begin
            stat.more = idx_p1 < {1'b0, count_reg};
        end else begin
            stat.more = idx_reg < count_reg;
        end
    end

    always_comb begin
        req_next      = req_reg;
        code_next     = code_reg;
        pos_next      = pos_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        rslot_next    = rslot_reg;
        wslot_next    = wslot_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        code_out_next = code_out_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_waddr     = wslot_reg;
        ram_wdata     = code_reg;
        ram_re        = 1'b0;
        ram_raddr     = rslot_reg;
        code_ext      = '0;

        if (cmd.capture) begin
            req_next  = req_type_t'(s_tuser[1:0]);
            code_next = s_tdata[SW-1:0];
            pos_next  = s_tdata[ITEM_W +: POS_W];
        end

        if (cmd.dispatch) begin
            status_next   = STATUS_OK;
            found_next    = 1'b0;
            code_out_next = '0;
            case (req_reg)
                REQ_ENQ: begin
                    if (full) begin
                        status_next = STATUS_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        ram_waddr  = wrap_add(head_reg, count_x);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_DEQ: begin
                    if (empty) begin
                        status_next = STATUS_EMPTY;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = head_reg;
                    end
                end
                REQ_SEARCH: begin
                    if (!empty) begin
                        ram_re     = 1'b1;
                        ram_raddr  = head_reg;
                        rslot_next = head_reg;
                        idx_next   = CNT_W'(1);
                    end
                end
                REQ_REMOVE: begin
                    if (pos_bad) begin
                        status_next = STATUS_NOPOS;
                    end else if (!pos_zero) begin
                        if (pos_x == count_x) begin
                            // last entry: nothing to close up
                            count_next = count_reg - CNT_W'(1);
                        end else begin
                            wslot_next = wrap_add(head_reg, pos_x - CMP_W'(1));
                            ram_re     = 1'b1;
                            ram_raddr  = wrap_add(head_reg, pos_x);
                            rslot_next = ram_raddr;
                            idx_next   = pos_x[CNT_W-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.deq_pop) begin
            code_out_next = ram_rdata;
            head_next     = wrap_add(head_reg, CMP_W'(1));
            count_next    = count_reg - CNT_W'(1);
        end

        if (cmd.scan_step) begin
            if (ram_rdata == code_reg) begin
                found_next = 1'b1;
            end
            if (stat.more) begin
                ram_re     = 1'b1;
                ram_raddr  = wrap_add(rslot_reg, CMP_W'(1));
                rslot_next = ram_raddr;
                idx_next   = idx_p1[CNT_W-1:0];
            end
        end

        if (cmd.shift_step) begin
            ram_we     = 1'b1;
            ram_waddr  = wslot_reg;
            ram_wdata  = ram_rdata;
            wslot_next = rslot_reg;
            if (stat.more) begin
                ram_re     = 1'b1;
                ram_raddr  = wrap_add(rslot_reg, CMP_W'(1));
                rslot_next = ram_raddr;
                idx_next   = idx_p1[CNT_W-1:0];
            end else begin
                count_next = count_reg - CNT_W'(1);
            end
        end

        if (cmd.out_load) begin
            code_ext[SW-1:0]              = code_out_reg;
            m_tdata_next                  = '0;
            m_tdata_next[ITEM_W-1:0]      = code_ext;
            m_tdata_next[ITEM_W +: OCC_W] = count_x[OCC_W-1:0];
            m_tuser_next                  = {found_reg, status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        code_reg     <= code_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        rslot_reg    <= rslot_next;
        wslot_reg    <= wslot_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        code_out_reg <= code_out_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

@@ hw/rtl/fwsr_ctrl.sv @@
// Controller: request sequencing state machine and output valid.
module fwsr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  fwsr_pkg::stat_t stat,
    output fwsr_pkg::cmd_t  cmd
);

    import fwsr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_DEQ      = 6'b000100,
        ST_SCAN     = 6'b001000,
        ST_SHIFT    = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.dispatch = 1'b1;
                if (stat.go_deq) begin
                    state_next = ST_DEQ;
                end else if (stat.go_scan) begin
                    state_next = ST_SCAN;
                end else if (stat.go_shift) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DEQ: begin
                cmd.deq_pop = 1'b1;
                state_next  = ST_DONE;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (!stat.more) begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (!stat.more) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to be free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

@@ hw/rtl/fifo_with_search_and_remove.sv @@
// A new request is taken only after its predecessor's result is loaded into the output register;
// search and removal walk the entry RAM through its single read port.
// Reset (aresetn low, synchronous) empties the queue and clears the output valid;
// the entry RAM is not cleared.
module fifo_with_search_and_remove #(
    parameter int DEPTH      = fwsr_pkg::DEPTH_DEF,
    parameter int CODE_WIDTH = fwsr_pkg::CODE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fwsr_pkg::S_TDATA_W-1:0] s_tdata,  // item_code[31:0], position[36:32]
    input  logic [fwsr_pkg::S_TUSER_W-1:0] s_tuser,  // req_type[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fwsr_pkg::M_TDATA_W-1:0] m_tdata,  // out_code[31:0], occupancy[36:32]
    output logic [fwsr_pkg::M_TUSER_W-1:0] m_tuser   // status[1:0], found[2]
);

    import fwsr_pkg::*;

    localparam int SW    = (CODE_WIDTH < ITEM_W) ? CODE_WIDTH : ITEM_W;
    localparam int IDX_W = $clog2(DEPTH);

    cmd_t             cmd;
    stat_t            stat;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [SW-1:0]    ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [SW-1:0]    ram_rdata;

    fwsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fwsr_datapath #(
        .DEPTH      (DEPTH),
        .CODE_WIDTH (CODE_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    fwsr_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ hw/rtl/fwsr_checker.sv @@
// Port-level checker for the search-and-remove FIFO, bound to the top level.
`include "fifo_with_search_and_remove_macros.svh"

module fwsr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fwsr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [fwsr_pkg::M_TUSER_W-1:0] m_tuser
);

    import fwsr_pkg::*;

    logic empty_zero;

    assign empty_zero = (m_tdata[ITEM_W-1:0] == '0) && (m_tdata[ITEM_W +: OCC_W] == '0);

    `FWSR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `FWSR_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `FWSR_ASSERT_IMM(a_empty_result, m_tvalid && (m_tuser[1:0] == STATUS_EMPTY), empty_zero)
    `FWSR_ASSERT_IMM(a_found_ok, m_tvalid && m_tuser[2], m_tuser[1:0] == STATUS_OK)

endmodule

bind fifo_with_search_and_remove fwsr_checker u_fwsr_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for the FIFO with search and remove-at-position.
module testbench;

    import fwsr_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEF;

    typedef struct {
        status_t     status;
        logic [31:0] out_code;
        logic        found;
        logic [4:0]  occupancy;
    } fifo_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // item_code[31:0], position[36:32]
    logic [S_TUSER_W-1:0] s_tuser  = '0;  // req_type[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // out_code[31:0], occupancy[36:32]
    logic [M_TUSER_W-1:0] m_tuser;   // status[1:0], found[2]

    logic [31:0]  held_codes[$];
    fifo_result_t expected_results[$];
    fifo_result_t seen_result;
    fifo_result_t want_result;

    int  mismatch_count   = 0;
    int  unexpected_count = 0;
    bit  sender_gaps      = 1'b1;
    bit  receiver_stalls  = 1'b1;
    int  stall_left       = 0;

    fifo_with_search_and_remove u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [31:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            3, 4, 5: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // Applies one accepted request to the local queue image and queues its result.
    function automatic void predict_queue_op(req_type_t rq, logic [31:0] code,
                                             logic [4:0] pos);
        fifo_result_t res;
        res.status   = STATUS_OK;
        res.out_code = '0;
        res.found    = 1'b0;
        case (rq)
            REQ_ENQ: begin
                if (held_codes.size() >= QUEUE_DEPTH) res.status = STATUS_FULL;
                else held_codes.push_back(code);
            end
            REQ_DEQ: begin
                if (held_codes.size() == 0) res.status = STATUS_EMPTY;
                else res.out_code = held_codes.pop_front();
            end
            REQ_SEARCH: begin
                foreach (held_codes[i])
                    if (held_codes[i] == code) res.found = 1'b1;
            end
            default: begin
                if (pos > held_codes.size()) res.status = STATUS_NOPOS;
                else if (pos != 0) held_codes.delete(pos - 1);
            end
        endcase
        res.occupancy = 5'(held_codes.size());
        expected_results.push_back(res);
    endfunction

    task automatic send_request(input req_type_t rq, input logic [31:0] code,
                                input logic [4:0] pos);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, pos, code};
        s_tuser  <= rq;
        do @(posedge aclk); while (!s_tready);
        predict_queue_op(rq, code, pos);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_for_results();
        while (expected_results.size() > 0) @(posedge aclk);
    endtask

    task automatic test_reset();
        aresetn <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic test_empty_queue();
        send_request(REQ_DEQ, 32'h1234_5678, 5'd0);
        send_request(REQ_SEARCH, 32'h0000_0000, 5'd0);
        send_request(REQ_REMOVE, 32'h0, 5'd0);
        send_request(REQ_REMOVE, 32'h0, 5'd1);
    endtask

    task automatic test_full_queue();
        logic [31:0] fill_codes[QUEUE_DEPTH];
        fill_codes[0] = 32'h8000_0000;
        fill_codes[1] = 32'h7FFF_FFFF;
        fill_codes[2] = 32'h0000_0000;
        fill_codes[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < QUEUE_DEPTH; i++) fill_codes[i] = 32'h100 + i;
        for (int i = 0; i < QUEUE_DEPTH; i++) send_request(REQ_ENQ, fill_codes[i], 5'd31);
        send_request(REQ_ENQ, 32'hDEAD_BEEF, 5'd0);
        send_request(REQ_SEARCH, 32'h7FFF_FFFF, 5'd0);
        send_request(REQ_SEARCH, 32'hDEAD_BEEF, 5'd0);
        send_request(REQ_REMOVE, 32'h0, 5'd16);
        send_request(REQ_REMOVE, 32'h0, 5'd1);
        send_request(REQ_REMOVE, 32'h0, 5'd0);
        send_request(REQ_REMOVE, 32'h0, 5'd31);
        send_request(REQ_DEQ, 32'h0, 5'd0);
    endtask

    task automatic test_random_traffic(input int count, input int enq_pct,
                                       input int deq_pct);
        req_type_t   rq;
        logic [31:0] code;
        logic [4:0]  pos;
        int          r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < enq_pct) rq = REQ_ENQ;
            else if (r < enq_pct + deq_pct) rq = REQ_DEQ;
            else if (r % 2 == 0) rq = REQ_SEARCH;
            else rq = REQ_REMOVE;
            code = pick_code();
            if (rq == REQ_SEARCH && held_codes.size() > 0 && $urandom_range(0, 1))
                code = held_codes[$urandom_range(0, held_codes.size() - 1)];
            if ($urandom_range(0, 99) < 85) pos = 5'($urandom_range(0, held_codes.size() + 1));
            else pos = 5'($urandom_range(0, 31));
            send_request(rq, code, pos);
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result.status    = status_t'(m_tuser[1:0]);
            seen_result.found     = m_tuser[2];
            seen_result.out_code  = m_tdata[31:0];
            seen_result.occupancy = m_tdata[36:32];
            if (expected_results.size() == 0) begin
                unexpected_count++;
                if (unexpected_count + mismatch_count <= 10)
                    $display("unexpected transfer: status %0d code %h found %0d occ %0d",
                             seen_result.status, seen_result.out_code,
                             seen_result.found, seen_result.occupancy);
            end else begin
                want_result = expected_results.pop_front();
                if (seen_result.status !== want_result.status ||
                    seen_result.out_code !== want_result.out_code ||
                    seen_result.found !== want_result.found ||
                    seen_result.occupancy !== want_result.occupancy) begin
                    mismatch_count++;
                    if (unexpected_count + mismatch_count <= 10)
                        $display("mismatch: exp status %0d code %h found %0d occ %0d, %s",
                                 want_result.status, want_result.out_code,
                                 want_result.found, want_result.occupancy,
                                 $sformatf("got status %0d code %h found %0d occ %0d",
                                           seen_result.status, seen_result.out_code,
                                           seen_result.found, seen_result.occupancy));
                end
            end
        end
    end

    initial begin
        test_reset();
        test_empty_queue();
        test_full_queue();
        test_random_traffic(400, 55, 15);
        stop_sending();
        wait_for_results();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        test_random_traffic(400, 35, 35);
        sender_gaps = 1'b1;
        test_random_traffic(400, 20, 55);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b1;
        test_random_traffic(400, 40, 25);
        stop_sending();
        wait_for_results();
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0 && unexpected_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
